### sv/rrs_pkg.sv
// Package for the round-robin sleep scheduler: slot state codes, action
// codes, field widths and the command bus shared by the controller and cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rrs_pkg;

  // Field widths
  localparam int ACT_W      = 3;
  localparam int SLOT_W     = 4;
  localparam int STATE_W    = 3;
  localparam int DUR_W      = 32;
  localparam int TICK_W     = 32;

  // Default number of process slots
  localparam int NUM_SLOTS_DEF = 16;

  // Slot state codes
  typedef enum logic [STATE_W-1:0] {
    ST_FREE     = 3'd0,
    ST_BLOCKED  = 3'd1,
    ST_RUNNABLE = 3'd2,
    ST_SLEEPING = 3'd3,
    ST_BROKEN   = 3'd4
  } slot_st_t;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_TICK  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PICK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SLEEP = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SET   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLAIM = 3'd4;
  localparam logic [ACT_W-1:0] ACT_KILL  = 3'd5;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } ctrl_st_t;

  // Broadcast command bus from the controller to every cell
  typedef struct packed {
    logic              scan_on;    // token holder evaluates this cycle
    logic              scan_load;  // place the token at the start cell
    logic              scan_step;  // pass the token to the next cell
    logic              claim;      // scan looks for a free slot, else runnable
    logic              wr_sleep;   // put the selected slot to sleep
    logic              wr_set;     // overwrite the selected slot's state
    logic              wr_kill;    // free the selected slot if it is live
    slot_st_t          set_state;
    logic [DUR_W-1:0]  duration;
    logic [TICK_W-1:0] tick;
  } cell_cmd_t;

endpackage

`default_nettype wire

### sv/rrs_cell.sv
// One process slot of the scheduler: state code, sleep record and scan token.
// The token moves to the next cell each scan step. Depends on rrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrs_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  rrs_pkg::cell_cmd_t   cmd,
  input  wire                  sel,
  input  wire                  start,
  input  wire                  token_in,
  output logic                 token_out,
  output logic                 hit,
  output rrs_pkg::slot_st_t    state_out
);

  rrs_pkg::slot_st_t              state_r, state_nxt;
  logic                           token_r, token_nxt;
  logic [rrs_pkg::TICK_W-1:0]     start_r;
  logic [rrs_pkg::DUR_W-1:0]      len_r;
  logic [rrs_pkg::TICK_W-1:0]     elapsed;
  logic                           woke;

  // Check whether the sleep has run out (ticks counted modulo 2^32)
  assign elapsed = cmd.tick - start_r;
  assign woke    = (state_r == rrs_pkg::ST_SLEEPING) && (elapsed >= len_r);

  // Report a hit when this cell holds the token and matches the scan
  always_comb begin
    hit = 1'b0;
    if (cmd.scan_on && token_r) begin
      if (cmd.claim) begin
        hit = (state_r == rrs_pkg::ST_FREE);
      end else begin
        hit = (state_r == rrs_pkg::ST_RUNNABLE) || woke;
      end
    end
  end

  // Update the state code
  always_comb begin
    state_nxt = state_r;
    if (hit) begin
      state_nxt = rrs_pkg::ST_RUNNABLE;
    end else if (sel) begin
      if (cmd.wr_sleep) begin
        state_nxt = rrs_pkg::ST_SLEEPING;
      end else if (cmd.wr_set) begin
        state_nxt = cmd.set_state;
      end else if (cmd.wr_kill && ((state_r == rrs_pkg::ST_BLOCKED) ||
                                   (state_r == rrs_pkg::ST_RUNNABLE) ||
                                   (state_r == rrs_pkg::ST_SLEEPING))) begin
        state_nxt = rrs_pkg::ST_FREE;
      end
    end
  end

  // Load or pass the scan token
  always_comb begin
    token_nxt = token_r;
    if (cmd.scan_load) begin
      token_nxt = start;
    end else if (cmd.scan_step) begin
      token_nxt = token_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrs_pkg::ST_FREE;
      token_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      token_r <= token_nxt;
    end
  end

  // Record the sleep start and length
  always_ff @(posedge clk) begin
    if (sel && cmd.wr_sleep) begin
      start_r <= cmd.tick;
      len_r   <= cmd.duration;
    end
  end

  assign token_out = token_r;
  assign state_out = state_r;

endmodule

`default_nettype wire

### sv/rrs_ctrl.sv
// Controller of the scheduler: handshakes, tick counter, scan sequencing and
// the output register. Drives the command bus of the cell row. Depends on rrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrs_ctrl #(
  parameter int NUM_SLOTS = rrs_pkg::NUM_SLOTS_DEF,
  parameter int IDX_W     = $clog2(NUM_SLOTS)
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire [rrs_pkg::ACT_W-1:0]     in_action,
  input  wire [rrs_pkg::SLOT_W-1:0]    in_slot,
  input  wire [rrs_pkg::STATE_W-1:0]   in_new_state,
  input  wire [rrs_pkg::DUR_W-1:0]     in_duration,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         out_status,
  output logic [rrs_pkg::SLOT_W-1:0]   out_chosen_slot,
  output rrs_pkg::cell_cmd_t           cmd,
  output logic [IDX_W-1:0]             tgt_idx,
  output logic                         tgt_inr,
  output logic [IDX_W-1:0]             start_idx,
  input  rrs_pkg::slot_st_t            tgt_state,
  input  wire                          any_hit
);

  localparam int CMP_W = ((IDX_W > rrs_pkg::SLOT_W) ? IDX_W : rrs_pkg::SLOT_W) + 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  rrs_pkg::ctrl_st_t              state_r, state_nxt;
  logic [rrs_pkg::TICK_W-1:0]     tick_r, tick_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [IDX_W-1:0]               idx_r, idx_nxt;
  logic                           claim_r, claim_nxt;
  logic [rrs_pkg::SLOT_W-1:0]     slot_r, slot_nxt;
  logic                           res_status_r, res_status_nxt;
  logic [rrs_pkg::SLOT_W-1:0]     res_slot_r, res_slot_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_status_r;
  logic [rrs_pkg::SLOT_W-1:0]     out_slot_r;
  logic                           in_fire;
  logic                           out_load;
  logic                           kill_ok;
  logic [CMP_W-1:0]               slot_mod;
  logic [CMP_W-1:0]               slot_inc;

  assign in_fire  = in_valid && (state_r == rrs_pkg::S_IDLE);
  assign in_stall = (state_r != rrs_pkg::S_IDLE);
  assign out_load = (state_r == rrs_pkg::S_EMIT) && (!out_valid_r || !out_stall);

  // Reduce the current slot modulo the slot count (slot is at most 15)
  always_comb begin
    slot_mod = CMP_W'(in_slot);
    for (int k = 0; k < 8; k++) begin
      if (slot_mod >= CMP_W'(NUM_SLOTS)) begin
        slot_mod = slot_mod - CMP_W'(NUM_SLOTS);
      end
    end
  end

  // Start the pick scan at the slot after the current one
  assign slot_inc = slot_mod + CMP_W'(1);

  always_comb begin
    if (in_action == rrs_pkg::ACT_CLAIM) begin
      start_idx = IDX_W'(1);
    end else if (slot_inc == CMP_W'(NUM_SLOTS)) begin
      start_idx = '0;
    end else begin
      start_idx = IDX_W'(slot_inc);
    end
  end

  // Decode the target slot of sleep, set state and kill
  assign tgt_inr = CMP_W'(in_slot) < CMP_W'(NUM_SLOTS);
  assign tgt_idx = IDX_W'(in_slot);
  assign kill_ok = tgt_inr && ((tgt_state == rrs_pkg::ST_BLOCKED) ||
                               (tgt_state == rrs_pkg::ST_RUNNABLE) ||
                               (tgt_state == rrs_pkg::ST_SLEEPING));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrs_pkg::S_IDLE: begin
        if (in_fire) begin
          if ((in_action == rrs_pkg::ACT_PICK) || (in_action == rrs_pkg::ACT_CLAIM)) begin
            state_nxt = rrs_pkg::S_SCAN;
          end else begin
            state_nxt = rrs_pkg::S_EMIT;
          end
        end
      end
      rrs_pkg::S_SCAN: begin
        if (any_hit || (cnt_r == CNT_W'(1))) begin
          state_nxt = rrs_pkg::S_EMIT;
        end
      end
      rrs_pkg::S_EMIT: begin
        if (out_load) begin
          state_nxt = rrs_pkg::S_IDLE;
        end
      end
      default: state_nxt = rrs_pkg::S_IDLE;
    endcase
  end

  // Outputs: command bus, scan counters and result
  always_comb begin
    cmd            = '0;
    cmd.tick       = tick_r;
    cmd.duration   = in_duration;
    cmd.set_state  = rrs_pkg::slot_st_t'(in_new_state);
    cmd.claim      = claim_r;
    tick_nxt       = tick_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    claim_nxt      = claim_r;
    slot_nxt       = slot_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && out_stall;
    case (state_r)
      rrs_pkg::S_IDLE: begin
        if (in_fire) begin
          slot_nxt       = in_slot;
          res_status_nxt = 1'b0;
          res_slot_nxt   = in_slot;
          idx_nxt        = start_idx;
          case (in_action)
            rrs_pkg::ACT_TICK: begin
              tick_nxt = tick_r + rrs_pkg::TICK_W'(1);
            end
            rrs_pkg::ACT_PICK: begin
              cmd.scan_load = 1'b1;
              claim_nxt     = 1'b0;
              cnt_nxt       = CNT_W'(NUM_SLOTS);
            end
            rrs_pkg::ACT_SLEEP: begin
              cmd.wr_sleep = 1'b1;
            end
            rrs_pkg::ACT_SET: begin
              cmd.wr_set = (in_new_state <= rrs_pkg::STATE_W'(rrs_pkg::ST_BROKEN));
            end
            rrs_pkg::ACT_CLAIM: begin
              cmd.scan_load = 1'b1;
              claim_nxt     = 1'b1;
              cnt_nxt       = CNT_W'(NUM_SLOTS - 1);
            end
            rrs_pkg::ACT_KILL: begin
              cmd.wr_kill    = 1'b1;
              res_status_nxt = !kill_ok;
            end
            default: begin
            end
          endcase
        end
      end
      rrs_pkg::S_SCAN: begin
        cmd.scan_on = 1'b1;
        if (any_hit) begin
          res_status_nxt = 1'b0;
          res_slot_nxt   = rrs_pkg::SLOT_W'(idx_r);
        end else begin
          cmd.scan_step  = 1'b1;
          res_status_nxt = 1'b1;
          res_slot_nxt   = slot_r;
          cnt_nxt        = cnt_r - CNT_W'(1);
          if (idx_r == IDX_W'(NUM_SLOTS - 1)) begin
            idx_nxt = '0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      rrs_pkg::S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrs_pkg::S_IDLE;
      tick_r      <= rrs_pkg::TICK_W'(1);
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
      claim_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      claim_r     <= claim_nxt;
    end
  end

  // Hold the pending result and the output payload
  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_chosen_slot = out_slot_r;

endmodule

`default_nettype wire

### sv/round_robin_sleep_scheduler.sv
// Round-robin sleep scheduler: a ring of NUM_SLOTS slot cells and its controller.
// Each item takes one transfer in and gives one result. Tick, sleep, set state,
// kill and unused actions go from idle to the emit state, where the result
// register loads once the output is free. Pick and claim pass a token around
// the cell ring, one slot per cycle, before the emit state; a pick visits at
// most NUM_SLOTS slots and a claim at most NUM_SLOTS - 1. A new item is
// accepted the cycle after the previous result enters the output register,
// even if that result is still stalled.
// Depends on rrs_pkg, rrs_ctrl and rrs_cell.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_sleep_scheduler #(
  parameter int NUM_SLOTS = rrs_pkg::NUM_SLOTS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire [rrs_pkg::ACT_W-1:0]     in_action,
  input  wire [rrs_pkg::SLOT_W-1:0]    in_slot,
  input  wire [rrs_pkg::STATE_W-1:0]   in_new_state,
  input  wire [rrs_pkg::DUR_W-1:0]     in_duration,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         out_status,
  output logic [rrs_pkg::SLOT_W-1:0]   out_chosen_slot
);

  localparam int IDX_W = $clog2(NUM_SLOTS);

  rrs_pkg::cell_cmd_t            cmd;
  logic [IDX_W-1:0]              tgt_idx;
  logic                          tgt_inr;
  logic [IDX_W-1:0]              start_idx;
  rrs_pkg::slot_st_t             tgt_state;
  logic                          any_hit;
  logic [NUM_SLOTS-1:0]          sel;
  logic [NUM_SLOTS-1:0]          start;
  logic [NUM_SLOTS-1:0]          token;
  logic [NUM_SLOTS-1:0]          hit;
  rrs_pkg::slot_st_t             cell_state [NUM_SLOTS];

  rrs_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_slot         (in_slot),
    .in_new_state    (in_new_state),
    .in_duration     (in_duration),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_chosen_slot (out_chosen_slot),
    .cmd             (cmd),
    .tgt_idx         (tgt_idx),
    .tgt_inr         (tgt_inr),
    .start_idx       (start_idx),
    .tgt_state       (tgt_state),
    .any_hit         (any_hit)
  );

  // Build the ring of slot cells
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    assign sel[i]   = tgt_inr && (tgt_idx == IDX_W'(i));
    assign start[i] = (start_idx == IDX_W'(i));

    rrs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .sel       (sel[i]),
      .start     (start[i]),
      .token_in  (token[(i + NUM_SLOTS - 1) % NUM_SLOTS]),
      .token_out (token[i]),
      .hit       (hit[i]),
      .state_out (cell_state[i])
    );
  end

  assign any_hit = |hit;

  // Read the target slot's state for kill
  always_comb begin
    logic [rrs_pkg::STATE_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      acc = acc | ({rrs_pkg::STATE_W{sel[i]}} & cell_state[i]);
    end
    tgt_state = rrs_pkg::slot_st_t'(acc);
  end

endmodule

`default_nettype wire

### dv/round_robin_sleep_scheduler_tb.sv
// Self-checking testbench for round_robin_sleep_scheduler: directed and random
// scheduler traffic checked against a cycle-free predictor of the slot table.
// Depends on rrs_pkg and the round_robin_sleep_scheduler RTL.
`timescale 1ns / 1ps

module round_robin_sleep_scheduler_tb;

  localparam int NSLOT = rrs_pkg::NUM_SLOTS_DEF;

  // Codes outside the defined ranges
  localparam logic [rrs_pkg::ACT_W-1:0]   ACT_SPARE6 = 3'd6;
  localparam logic [rrs_pkg::ACT_W-1:0]   ACT_SPARE7 = 3'd7;
  localparam logic [rrs_pkg::STATE_W-1:0] BAD_STATE  = 3'd7;

  typedef struct {
    logic [rrs_pkg::ACT_W-1:0]   action;
    logic [rrs_pkg::SLOT_W-1:0]  slot;
    logic [rrs_pkg::STATE_W-1:0] new_state;
    logic [rrs_pkg::DUR_W-1:0]   duration;
  } sched_cmd_t;

  typedef struct {
    logic                       status;
    logic [rrs_pkg::SLOT_W-1:0] chosen;
  } sched_result_t;

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [rrs_pkg::ACT_W-1:0]    in_action = '0;
  logic [rrs_pkg::SLOT_W-1:0]   in_slot = '0;
  logic [rrs_pkg::STATE_W-1:0]  in_new_state = '0;
  logic [rrs_pkg::DUR_W-1:0]    in_duration = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_status;
  logic [rrs_pkg::SLOT_W-1:0]   out_chosen_slot;

  // Predicted scheduler state
  rrs_pkg::slot_st_t            slot_tbl [NSLOT];
  logic [rrs_pkg::TICK_W-1:0]   sleep_from [NSLOT];
  logic [rrs_pkg::DUR_W-1:0]    sleep_len [NSLOT];
  bit                           rec_written [NSLOT];
  logic [rrs_pkg::TICK_W-1:0]   tick_now;

  sched_result_t       pending_q[$];
  sched_result_t       last_result;
  int                  fail_count = 0;
  int                  items_sent = 0;
  int                  tx_idle_pct = 0;
  int                  rx_stall_pct = 0;
  logic                rx_hold = 1'b0;

  round_robin_sleep_scheduler #(.NUM_SLOTS(NSLOT)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_slot         (in_slot),
    .in_new_state    (in_new_state),
    .in_duration     (in_duration),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_chosen_slot (out_chosen_slot)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2000000;
    $display("round_robin_sleep_scheduler_tb NOT OK");
    $finish;
  end

  // Apply one accepted item to the slot table and return its result
  function automatic sched_result_t schedule_step(input sched_cmd_t c);
    sched_result_t r;
    int            i;
    int            idx;
    bit            found;
    logic [31:0]   elapsed;
    r.status = 1'b0;
    r.chosen = c.slot;
    found    = 1'b0;
    case (c.action)
      rrs_pkg::ACT_TICK: tick_now = tick_now + 1;
      rrs_pkg::ACT_PICK: begin
        // Scan from the slot after the current one, waking due sleepers
        idx = c.slot % NSLOT;
        for (i = 0; i < NSLOT; i++) begin
          if (!found) begin
            idx = (idx + 1) % NSLOT;
            elapsed = tick_now - sleep_from[idx];
            if (slot_tbl[idx] == rrs_pkg::ST_SLEEPING && elapsed >= sleep_len[idx])
              slot_tbl[idx] = rrs_pkg::ST_RUNNABLE;
            if (slot_tbl[idx] == rrs_pkg::ST_RUNNABLE) begin
              found    = 1'b1;
              r.chosen = rrs_pkg::SLOT_W'(idx);
            end
          end
        end
        if (!found) r.status = 1'b1;
      end
      rrs_pkg::ACT_SLEEP: begin
        if (c.slot < NSLOT) begin
          sleep_from[c.slot]  = tick_now;
          sleep_len[c.slot]   = c.duration;
          rec_written[c.slot] = 1'b1;
          slot_tbl[c.slot]    = rrs_pkg::ST_SLEEPING;
        end
      end
      rrs_pkg::ACT_SET: begin
        if (c.slot < NSLOT && c.new_state <= rrs_pkg::ST_BROKEN)
          slot_tbl[c.slot] = rrs_pkg::slot_st_t'(c.new_state);
      end
      rrs_pkg::ACT_CLAIM: begin
        // Lowest free slot from 1 becomes runnable
        for (i = 1; i < NSLOT; i++) begin
          if (!found && slot_tbl[i] == rrs_pkg::ST_FREE) begin
            slot_tbl[i] = rrs_pkg::ST_RUNNABLE;
            found       = 1'b1;
            r.chosen    = rrs_pkg::SLOT_W'(i);
          end
        end
        if (!found) r.status = 1'b1;
      end
      rrs_pkg::ACT_KILL: begin
        if (c.slot < NSLOT && (slot_tbl[c.slot] == rrs_pkg::ST_BLOCKED ||
            slot_tbl[c.slot] == rrs_pkg::ST_RUNNABLE ||
            slot_tbl[c.slot] == rrs_pkg::ST_SLEEPING))
          slot_tbl[c.slot] = rrs_pkg::ST_FREE;
        else
          r.status = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one item, hold it until the transfer, then record its expected result
  task automatic send_cmd(input sched_cmd_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= c.action;
    in_slot      <= c.slot;
    in_new_state <= c.new_state;
    in_duration  <= c.duration;
    do @(posedge clk); while (in_stall);
    last_result = schedule_step(c);
    pending_q.push_back(last_result);
    items_sent++;
  endtask

  task automatic issue(input logic [rrs_pkg::ACT_W-1:0] act,
                       input logic [rrs_pkg::SLOT_W-1:0] s,
                       input logic [rrs_pkg::STATE_W-1:0] ns,
                       input logic [rrs_pkg::DUR_W-1:0] d);
    sched_cmd_t c;
    c.action    = act;
    c.slot      = s;
    c.new_state = ns;
    c.duration  = d;
    send_cmd(c);
  endtask

  // Drive the result stall and check each result transfer
  always @(posedge clk) begin : result_side
    sched_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result: status %0d, chosen_slot %0d",
               out_status, out_chosen_slot);
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_chosen_slot !== want.chosen) begin
          $error("chosen_slot: expected %0d, got %0d", want.chosen, out_chosen_slot);
          fail_count++;
        end
      end
    end
    out_stall <= rx_hold || ($urandom_range(99) < rx_stall_pct);
  end

  // Random slot, leaning toward slots that are in use
  function automatic logic [rrs_pkg::SLOT_W-1:0] busy_or_any_slot();
    logic [rrs_pkg::SLOT_W-1:0] s;
    int                         tries;
    s = rrs_pkg::SLOT_W'($urandom_range(NSLOT - 1));
    for (tries = 0; tries < NSLOT; tries++) begin
      if (slot_tbl[s] != rrs_pkg::ST_FREE) return s;
      s = rrs_pkg::SLOT_W'($urandom_range(NSLOT - 1));
    end
    return s;
  endfunction

  function automatic logic [rrs_pkg::DUR_W-1:0] random_duration();
    case ($urandom_range(3))
      0, 1:    return rrs_pkg::DUR_W'($urandom_range(6));
      2:       return rrs_pkg::DUR_W'($urandom_range(40));
      default: return $urandom();
    endcase
  endfunction

  function automatic sched_cmd_t random_cmd();
    sched_cmd_t c;
    int         r;
    r = $urandom_range(99);
    if      (r < 25) c.action = rrs_pkg::ACT_TICK;
    else if (r < 50) c.action = rrs_pkg::ACT_PICK;
    else if (r < 62) c.action = rrs_pkg::ACT_SLEEP;
    else if (r < 74) c.action = rrs_pkg::ACT_SET;
    else if (r < 86) c.action = rrs_pkg::ACT_CLAIM;
    else if (r < 96) c.action = rrs_pkg::ACT_KILL;
    else             c.action = $urandom_range(1) ? ACT_SPARE6 : ACT_SPARE7;
    c.slot      = $urandom_range(1) ? busy_or_any_slot() :
                                      rrs_pkg::SLOT_W'($urandom_range(NSLOT - 1));
    c.new_state = rrs_pkg::STATE_W'($urandom_range(7));
    c.duration  = random_duration();
    // Never revive a sleeper whose record was never written
    if (c.action == rrs_pkg::ACT_SET && c.new_state == rrs_pkg::ST_SLEEPING &&
        !rec_written[c.slot])
      c.new_state = rrs_pkg::ST_BLOCKED;
    return c;
  endfunction

  task automatic test_empty_and_claim();
    issue(rrs_pkg::ACT_PICK, 4'd0, rrs_pkg::ST_FREE, '0);
    issue(rrs_pkg::ACT_KILL, 4'd15, rrs_pkg::ST_FREE, '0);
    issue(rrs_pkg::ACT_TICK, 4'd15, BAD_STATE, '1);
    issue(rrs_pkg::ACT_CLAIM, 4'd9, rrs_pkg::ST_FREE, '0);
    issue(rrs_pkg::ACT_CLAIM, 4'd0, rrs_pkg::ST_FREE, '0);
    issue(rrs_pkg::ACT_PICK, 4'd1, rrs_pkg::ST_FREE, '0);
    issue(rrs_pkg::ACT_PICK, 4'd2, rrs_pkg::ST_FREE, '0);
  endtask

  task automatic test_sleep_wake();
    // Zero duration wakes at once; a huge one never does
    issue(rrs_pkg::ACT_SLEEP, 4'd2, rrs_pkg::ST_FREE, '0);
    issue(rrs_pkg::ACT_PICK, 4'd1, rrs_pkg::ST_FREE, '0);
    issue(rrs_pkg::ACT_SLEEP, 4'd1, rrs_pkg::ST_FREE, '1);
    issue(rrs_pkg::ACT_SLEEP, 4'd2, rrs_pkg::ST_FREE, 32'd2);
    issue(rrs_pkg::ACT_PICK, 4'd0, rrs_pkg::ST_FREE, '0);
    issue(rrs_pkg::ACT_TICK, 4'd0, rrs_pkg::ST_FREE, '0);
    issue(rrs_pkg::ACT_PICK, 4'd5, rrs_pkg::ST_FREE, '0);
    issue(rrs_pkg::ACT_TICK, 4'd0, rrs_pkg::ST_FREE, '0);
    issue(rrs_pkg::ACT_PICK, 4'd15, rrs_pkg::ST_FREE, '0);
  endtask

  task automatic test_set_and_kill();
    issue(rrs_pkg::ACT_SET, 4'd3, BAD_STATE, '0);
    issue(rrs_pkg::ACT_SET, 4'd3, rrs_pkg::ST_BROKEN, '0);
    issue(rrs_pkg::ACT_KILL, 4'd3, rrs_pkg::ST_FREE, '0);
    issue(rrs_pkg::ACT_SET, 4'd3, rrs_pkg::ST_FREE, '0);
    issue(rrs_pkg::ACT_KILL, 4'd2, rrs_pkg::ST_FREE, '0);
    issue(rrs_pkg::ACT_KILL, 4'd1, rrs_pkg::ST_FREE, '0);
    issue(rrs_pkg::ACT_KILL, 4'd1, rrs_pkg::ST_FREE, '0);
    // Slot 1 keeps its old sleep record
    issue(rrs_pkg::ACT_SET, 4'd1, rrs_pkg::ST_SLEEPING, '0);
  endtask

  task automatic test_unused_actions();
    issue(ACT_SPARE6, 4'd15, BAD_STATE, '1);
    issue(ACT_SPARE7, 4'd0, rrs_pkg::ST_FREE, '0);
  endtask

  // Some claim/sleep/tick/pick lifecycles and fill bursts, mostly noise
  task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
    int                         first;
    int                         r;
    int                         k;
    logic [rrs_pkg::SLOT_W-1:0] s;
    logic [rrs_pkg::DUR_W-1:0]  d;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    first = items_sent;
    while (items_sent - first < n_items) begin
      r = $urandom_range(99);
      if (r < 35) begin
        issue(rrs_pkg::ACT_CLAIM, rrs_pkg::SLOT_W'($urandom_range(NSLOT - 1)),
              rrs_pkg::STATE_W'($urandom_range(7)), $urandom());
        if (last_result.status == 1'b0) begin
          s = last_result.chosen;
          d = rrs_pkg::DUR_W'($urandom_range(5));
          issue(rrs_pkg::ACT_SLEEP, s, rrs_pkg::STATE_W'($urandom_range(7)), d);
          repeat ($urandom_range(d + 1))
            issue(rrs_pkg::ACT_TICK, rrs_pkg::SLOT_W'($urandom_range(NSLOT - 1)),
                  rrs_pkg::STATE_W'($urandom_range(7)), $urandom());
          issue(rrs_pkg::ACT_PICK, rrs_pkg::SLOT_W'($urandom_range(NSLOT - 1)),
                rrs_pkg::ST_FREE, '0);
          k = $urandom_range(2);
          if (k == 0) issue(rrs_pkg::ACT_KILL, s, rrs_pkg::ST_FREE, '0);
          else if (k == 1) issue(rrs_pkg::ACT_SET, s, rrs_pkg::ST_FREE, '0);
        end
      end else if (r < 40) begin
        repeat (NSLOT)
          issue(rrs_pkg::ACT_CLAIM, rrs_pkg::SLOT_W'($urandom_range(NSLOT - 1)),
                rrs_pkg::ST_FREE, '0);
      end else begin
        send_cmd(random_cmd());
      end
    end
  endtask

  // Hold the result side off long enough for the input to back up
  task automatic test_output_hold_off();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (30) send_cmd(random_cmd());
  endtask

  initial begin : main
    int i;
    int waited;
    for (i = 0; i < NSLOT; i++) begin
      slot_tbl[i]    = rrs_pkg::ST_FREE;
      sleep_from[i]  = '0;
      sleep_len[i]   = '0;
      rec_written[i] = 1'b0;
    end
    tick_now = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_empty_and_claim();
    test_sleep_wake();
    test_set_and_kill();
    test_unused_actions();
    test_random_traffic(210, 0, 0);
    test_random_traffic(210, 86, 0);
    test_output_hold_off();
    test_random_traffic(210, 0, 86);
    test_random_traffic(210, 7, 7);

    // Drain outstanding results, then allow for stray ones
    in_valid     <= 1'b0;
    rx_stall_pct = 0;
    waited = 0;
    while (pending_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (pending_q.size() != 0) begin
      $error("%0d results never arrived", pending_q.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("round_robin_sleep_scheduler_tb OK");
    else
      $display("round_robin_sleep_scheduler_tb NOT OK");
    $finish;
  end

endmodule
